FILE: rtl/core/rsa_pkg.sv
`default_nettype none

package rsa_pkg;

    typedef enum logic [1:0] {
        OP_ALLOC       = 2'd0,
        OP_RECLAIM     = 2'd1,
        OP_RECLAIM_ALL = 2'd2,
        OP_NONE        = 2'd3
    } t_op;

    typedef enum logic [0:0] {
        CFG_CAPACITY    = 1'b0,
        CFG_ALIGN_SHIFT = 1'b1
    } t_cfg_index;

    localparam logic [3:0] MAX_ALIGN_SHIFT = 4'd8;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic finish;
    } t_dp_cmd;

endpackage

`default_nettype wire

FILE: rtl/core/ring_staging_allocator.sv
// a request accepted in idle is loaded, then granted, then its free count is registered as the result
// no new request is taken until the controller has run that sequence and returned to idle
// a stalled result holds the controller in its last step until the result is taken
// reset (synchronous, active low): ring empty, head and tail 0, capacity 2^OFFSET_BITS,
// alignment 1 byte, no result pending
`default_nettype none

module ring_staging_allocator
    import rsa_pkg::*;
#(
    parameter int OFFSET_BITS = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [1:0]             i_op,
    input  wire logic [OFFSET_BITS:0]   i_req_size,
    input  wire logic [OFFSET_BITS:0]   i_release_point,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic                        o_granted,
    output logic [OFFSET_BITS-1:0]      o_grant_offset,
    output logic [OFFSET_BITS:0]        o_free_bytes,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [0:0]             i_cfg_index,
    input  wire logic [OFFSET_BITS:0]   i_cfg_data
);

    t_dp_cmd cmd;

    assign o_cfg_ready = 1'b1;

    rsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    rsa_datapath #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_op            (i_op),
        .i_req_size      (i_req_size),
        .i_release_point (i_release_point),
        .o_granted       (o_granted),
        .o_grant_offset  (o_grant_offset),
        .o_free_bytes    (o_free_bytes)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while a previous one is still in flight");

    a_refused_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_granted) |-> (o_grant_offset == '0))
        else $error("refused result carries a nonzero offset");

    a_free_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_free_bytes <= {1'b1, {OFFSET_BITS{1'b0}}}))
        else $error("free byte count above the largest capacity");

endmodule

`default_nettype wire

FILE: rtl/core/rsa_ctrl.sv
`default_nettype none

module rsa_ctrl
    import rsa_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_out_stall,
    output logic         o_in_stall,
    output logic         o_out_valid,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FREE
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.exec   = (r_state == ST_EXEC);
        o_cmd.finish = (r_state == ST_FREE) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_state <= ST_FREE;
                end
                ST_FREE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: rtl/core/rsa_datapath.sv
`default_nettype none

module rsa_datapath
    import rsa_pkg::*;
#(
    parameter int OFFSET_BITS = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_dp_cmd                i_cmd,
    input  wire logic                   i_cfg_we,
    input  wire logic [0:0]             i_cfg_index,
    input  wire logic [OFFSET_BITS:0]   i_cfg_data,
    input  wire logic [1:0]             i_op,
    input  wire logic [OFFSET_BITS:0]   i_req_size,
    input  wire logic [OFFSET_BITS:0]   i_release_point,
    output logic                        o_granted,
    output logic [OFFSET_BITS-1:0]      o_grant_offset,
    output logic [OFFSET_BITS:0]        o_free_bytes
);

    localparam int W = OFFSET_BITS + 1;
    localparam logic [W-1:0] CAP_MAX = {1'b1, {OFFSET_BITS{1'b0}}};

    logic [W-1:0]           r_eff_cap;
    logic [3:0]             r_align;
    logic [W-1:0]           r_head;
    logic [W-1:0]           r_tail;
    logic                   r_empty;
    t_op                    r_op;
    logic [W:0]             r_need;
    logic                   r_size_zero;
    logic [W-1:0]           r_rel;
    logic                   r_granted;
    logic [OFFSET_BITS-1:0] r_offset;
    logic                   r_out_granted;
    logic [OFFSET_BITS-1:0] r_out_offset;
    logic [W-1:0]           r_out_free;

    logic [W-1:0]           n_cap;
    logic [3:0]             n_align;
    logic [W-1:0]           sat_head;
    logic [W-1:0]           sat_tail;
    logic [W-1:0]           sat_rel;
    logic [W:0]             align_mask;
    logic [W:0]             need;

    logic [W-1:0]           room_end;
    logic [W-1:0]           gap;
    logic [W-1:0]           need_w;
    logic                   fit_cap;
    logic                   fit_end;
    logic                   fit_tail;
    logic                   fit_gap;
    logic [W-1:0]           n_head;
    logic [W-1:0]           n_tail;
    logic                   n_empty;
    logic                   n_granted;
    logic [W-1:0]           n_offset;
    logic [W-1:0]           free_cnt;

    // config decode, stored already clamped
    always_comb begin
        if (i_cfg_data == '0) begin
            n_cap = W'(1);
        end else if (i_cfg_data > CAP_MAX) begin
            n_cap = CAP_MAX;
        end else begin
            n_cap = i_cfg_data;
        end
        n_align = (i_cfg_data[3:0] > MAX_ALIGN_SHIFT) ? MAX_ALIGN_SHIFT : i_cfg_data[3:0];
    end

    // load stage
    always_comb begin
        sat_head   = (r_head > r_eff_cap) ? r_eff_cap : r_head;
        sat_tail   = (r_tail > r_eff_cap) ? r_eff_cap : r_tail;
        sat_rel    = (i_release_point > r_eff_cap) ? r_eff_cap : i_release_point;
        align_mask = ((W+1)'(1) << r_align) - (W+1)'(1);
        need       = ({1'b0, i_req_size} + align_mask) & ~align_mask;
    end

    // grant decision and pointer update for every op
    always_comb begin
        room_end  = r_eff_cap - r_head;
        gap       = r_tail - r_head;
        need_w    = r_need[W-1:0];
        fit_cap   = r_need <= {1'b0, r_eff_cap};
        fit_end   = r_need <= {1'b0, room_end};
        fit_tail  = r_need <= {1'b0, r_tail};
        fit_gap   = r_need <= {1'b0, gap};
        n_head    = r_head;
        n_tail    = r_tail;
        n_empty   = r_empty;
        n_granted = 1'b0;
        n_offset  = '0;
        unique case (r_op)
            OP_ALLOC: begin
                if (!r_size_zero && fit_cap) begin
                    if (r_empty) begin
                        n_offset  = fit_end ? r_head : '0;
                        n_head    = n_offset + need_w;
                        n_empty   = 1'b0;
                        n_granted = 1'b1;
                    end else if (r_head == r_tail) begin
                        n_granted = 1'b0;
                    end else if (r_head > r_tail) begin
                        if (fit_end) begin
                            n_offset  = r_head;
                            n_head    = r_head + need_w;
                            n_granted = 1'b1;
                        end else if (fit_tail) begin
                            n_head    = need_w;
                            n_granted = 1'b1;
                        end
                    end else if (fit_gap) begin
                        n_offset  = r_head;
                        n_head    = r_head + need_w;
                        n_granted = 1'b1;
                    end
                end
            end
            OP_RECLAIM: begin
                n_tail = r_rel;
                if (r_rel == r_head) begin
                    n_empty = 1'b1;
                end
            end
            OP_RECLAIM_ALL: begin
                n_head  = '0;
                n_tail  = '0;
                n_empty = 1'b1;
            end
            OP_NONE: begin
                n_granted = 1'b0;
            end
        endcase
    end

    // free count from committed pointers
    always_comb begin
        priority if (r_empty) begin
            free_cnt = r_eff_cap;
        end else if (r_head == r_tail) begin
            free_cnt = '0;
        end else if (r_head > r_tail) begin
            free_cnt = (r_eff_cap - r_head) + r_tail;
        end else begin
            free_cnt = r_tail - r_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_cap <= CAP_MAX;
            r_align   <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_empty   <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_CAPACITY:    r_eff_cap <= n_cap;
                    CFG_ALIGN_SHIFT: r_align   <= n_align;
                endcase
            end
            if (i_cmd.load) begin
                r_head <= sat_head;
                r_tail <= sat_tail;
            end else if (i_cmd.exec) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_empty <= n_empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= t_op'(i_op);
            r_need      <= need;
            r_size_zero <= (i_req_size == '0);
            r_rel       <= sat_rel;
        end
        if (i_cmd.exec) begin
            r_granted <= n_granted;
            r_offset  <= n_offset[OFFSET_BITS-1:0];
        end
        if (i_cmd.finish) begin
            r_out_granted <= r_granted;
            r_out_offset  <= r_offset;
            r_out_free    <= free_cnt;
        end
    end

    assign o_granted      = r_out_granted;
    assign o_grant_offset = r_out_offset;
    assign o_free_bytes   = r_out_free;

endmodule

`default_nettype wire
